@@ hdl/rwla_pkg.sv @@
// shared types and constants for the readers-writer lock arbiter
package rwla_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QIdxW = $clog2(QueueDepth);
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);
  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW = $clog2(MaxResults + 1);
  localparam logic [6:0] ReadersMax = 7'd127;

  typedef enum logic [2:0] {
    MODE_ENTER_READ  = 3'd0,
    MODE_ENTER_WRITE = 3'd1,
    MODE_EXIT_READ   = 3'd2,
    MODE_EXIT_WRITE  = 3'd3,
    MODE_TICK        = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_GRANT_NOW  = 3'd0,
    EV_QUEUED     = 3'd1,
    EV_GRANT_WAIT = 3'd2,
    EV_TIMEOUT    = 3'd3,
    EV_ACK        = 3'd4,
    EV_FULL       = 3'd5,
    EV_MISUSE     = 3'd6
  } event_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  thread_id;
    logic [15:0] timeout_ms;
  } req_t;

  typedef struct packed {
    logic [5:0] thread_id_res;
    logic [2:0] event_res;
    logic       last;
  } res_t;

endpackage

@@ hdl/rwla_req_fifo.sv @@
// front request queue: buffers accepted requests ahead of the lock engine
module rwla_req_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rwla_pkg::req_t  req_i,
  output logic            full_o,
  input  logic            take_i,
  output logic            avail_o,
  output rwla_pkg::req_t  req_o
);
  import rwla_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  logic       wptr_q, rptr_q;
  req_t       mem_q [2];

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign req_o   = mem_q[rptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if ((push_i && !full_o) && !(take_i && avail_o)) cnt_d = cnt_q + 2'd1;
    if (!(push_i && !full_o) && (take_i && avail_o)) cnt_d = cnt_q - 2'd1;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i && !full_o) wptr_q <= ~wptr_q;
      if (take_i && avail_o) rptr_q <= ~rptr_q;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wptr_q] <= req_i;
  end
endmodule

@@ hdl/rwla_engine.sv @@
// lock engine: carries out one request at a time, emits results one per cycle while the result queue has room
module rwla_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  rwla_pkg::req_t  req_i,
  output logic            take_o,
  output logic            res_valid_o,
  output rwla_pkg::res_t  res_o,
  input  logic            res_ready_i
);
  import rwla_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_POST  = 5'b00100,
    ST_REL   = 5'b01000,
    ST_ACK   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]       rd_act_q, rd_act_d;
  logic             wr_act_q, wr_act_d;
  logic [QCntW-1:0] rcnt_q, rcnt_d;
  logic [QCntW-1:0] wcnt_q, wcnt_d;
  logic [15:0]      now_q, now_d;
  logic [5:0]       rfifo_q [QueueDepth];
  logic [5:0]       wslot_q [QueueDepth];
  logic [15:0]      wdl_q   [QueueDepth];
  logic             whas_q  [QueueDepth];

  // scan / release position and reported-result count
  logic [QCntW-1:0]   pos_q, pos_d;
  logic [ResCntW-1:0] nres_q, nres_d;

  // result emission
  logic       emit;
  logic [5:0] e_tid;
  event_e     e_ev;

  // pending result of a multi-result request, held until its successor is known
  logic       pend_v_q;
  res_t       pend_q;
  logic       wr_out;
  res_t       out_res;

  // queue edits
  logic       rf_push, wf_push, wf_remove;
  logic [QIdxW-1:0] wf_rm_idx;

  logic [QIdxW-1:0] pidx;
  assign pidx = pos_q[QIdxW-1:0];

  mode_e mode;
  assign mode = mode_e'(req_i.mode);

  always_comb begin
    state_d   = state_q;
    rd_act_d  = rd_act_q;
    wr_act_d  = wr_act_q;
    rcnt_d    = rcnt_q;
    wcnt_d    = wcnt_q;
    now_d     = now_q;
    pos_d     = pos_q;
    nres_d    = nres_q;
    emit      = 1'b0;
    e_tid     = '0;
    e_ev      = EV_ACK;
    take_o    = 1'b0;
    rf_push   = 1'b0;
    wf_push   = 1'b0;
    wf_remove = 1'b0;
    wf_rm_idx = pidx;
    if (res_ready_i) begin
      case (state_q)
        ST_IDLE: begin
          if (avail_i) begin
            take_o = 1'b1;
            e_tid  = req_i.thread_id;
            case (mode)
              MODE_ENTER_READ: begin
                emit = 1'b1;
                if (!wr_act_q && wcnt_q == '0) begin
                  if (rd_act_q >= ReadersMax) e_ev = EV_FULL;
                  else begin
                    rd_act_d = rd_act_q + 7'd1;
                    e_ev = EV_GRANT_NOW;
                  end
                end else if (rcnt_q >= QCntW'(QueueDepth)) begin
                  e_ev = EV_FULL;
                end else begin
                  rf_push = 1'b1;
                  rcnt_d  = rcnt_q + QCntW'(1);
                  e_ev    = EV_QUEUED;
                end
              end
              MODE_ENTER_WRITE: begin
                emit = 1'b1;
                if (rd_act_q == '0 && !wr_act_q) begin
                  wr_act_d = 1'b1;
                  e_ev = EV_GRANT_NOW;
                end else if (wcnt_q >= QCntW'(QueueDepth)) begin
                  e_ev = EV_FULL;
                end else begin
                  wf_push = 1'b1;
                  wcnt_d  = wcnt_q + QCntW'(1);
                  e_ev    = EV_QUEUED;
                end
              end
              MODE_EXIT_READ: begin
                emit  = 1'b1;
                e_tid = '0;
                if (rd_act_q == '0) e_ev = EV_MISUSE;
                else begin
                  rd_act_d = rd_act_q - 7'd1;
                  if (rd_act_q == 7'd1 && wcnt_q != '0) begin
                    e_tid     = wslot_q[0];
                    e_ev      = EV_GRANT_WAIT;
                    wf_remove = 1'b1;
                    wf_rm_idx = '0;
                    wcnt_d    = wcnt_q - QCntW'(1);
                    wr_act_d  = 1'b1;
                  end else e_ev = EV_ACK;
                end
              end
              MODE_EXIT_WRITE: begin
                e_tid = '0;
                if (!wr_act_q) begin
                  emit = 1'b1;
                  e_ev = EV_MISUSE;
                end else begin
                  wr_act_d = 1'b0;
                  if (rcnt_q != '0) begin
                    pos_d   = '0;
                    nres_d  = '0;
                    state_d = ST_REL;
                  end else if (wcnt_q != '0) begin
                    emit      = 1'b1;
                    e_tid     = wslot_q[0];
                    e_ev      = EV_GRANT_WAIT;
                    wf_remove = 1'b1;
                    wf_rm_idx = '0;
                    wcnt_d    = wcnt_q - QCntW'(1);
                    wr_act_d  = 1'b1;
                  end else begin
                    emit = 1'b1;
                    e_ev = EV_ACK;
                  end
                end
              end
              MODE_TICK: begin
                now_d   = now_q + 16'd1;
                pos_d   = '0;
                nres_d  = '0;
                state_d = ST_SCAN;
              end
              default: begin
                emit  = 1'b1;
                e_tid = '0;
                e_ev  = EV_MISUSE;
              end
            endcase
          end
        end
        // one waiting writer examined per cycle while the result queue has room
        ST_SCAN: begin
          if (pos_q >= wcnt_q) begin
            state_d = ST_POST;
          end else if (whas_q[pidx] && wdl_q[pidx] == now_q) begin
            wf_remove = 1'b1;
            wcnt_d    = wcnt_q - QCntW'(1);
            if (nres_q < ResCntW'(MaxResults)) begin
              emit   = 1'b1;
              e_tid  = wslot_q[pidx];
              e_ev   = EV_TIMEOUT;
              nres_d = nres_q + ResCntW'(1);
            end
          end else begin
            pos_d = pos_q + QCntW'(1);
          end
        end
        // decide reader release after timeouts
        ST_POST: begin
          pos_d = '0;
          if (!wr_act_q && wcnt_q == '0 && rcnt_q != '0) state_d = ST_REL;
          else state_d = ST_ACK;
        end
        // release queued readers one per cycle while the result queue has room
        ST_REL: begin
          if (rd_act_q < ReadersMax) rd_act_d = rd_act_q + 7'd1;
          if (nres_q < ResCntW'(MaxResults)) begin
            emit   = 1'b1;
            e_tid  = rfifo_q[pidx];
            e_ev   = EV_GRANT_WAIT;
            nres_d = nres_q + ResCntW'(1);
          end
          pos_d = pos_q + QCntW'(1);
          if (pos_q + QCntW'(1) == rcnt_q) begin
            rcnt_d  = '0;
            state_d = ST_ACK;
          end
        end
        // close a multi-result request: flush the last one, or ack
        ST_ACK: begin
          state_d = ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  // result write: single results go straight out, others through the pending slot
  always_comb begin
    wr_out       = 1'b0;
    out_res      = pend_q;
    out_res.last = 1'b0;
    if (res_ready_i) begin
      if (state_q == ST_IDLE && emit) begin
        wr_out                = 1'b1;
        out_res.thread_id_res = e_tid;
        out_res.event_res     = e_ev;
        out_res.last          = 1'b1;
      end else if (state_q == ST_ACK) begin
        wr_out       = 1'b1;
        out_res.last = 1'b1;
        if (!pend_v_q) begin
          out_res.thread_id_res = '0;
          out_res.event_res     = EV_ACK;
        end
      end else if (emit && pend_v_q) begin
        wr_out = 1'b1;
      end
    end
  end

  assign res_valid_o = wr_out;
  assign res_o       = out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_act_q <= '0;
      wr_act_q <= 1'b0;
      rcnt_q <= '0;
      wcnt_q <= '0;
      now_q <= '0;
      pos_q <= '0;
      nres_q <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_act_q <= rd_act_d;
      wr_act_q <= wr_act_d;
      rcnt_q   <= rcnt_d;
      wcnt_q   <= wcnt_d;
      now_q    <= now_d;
      pos_q    <= pos_d;
      nres_q   <= nres_d;
      if (res_ready_i) begin
        if (state_q == ST_ACK) pend_v_q <= 1'b0;
        else if (emit && state_q != ST_IDLE) pend_v_q <= 1'b1;
      end
    end
  end

  // pending result payload
  always_ff @(posedge clk_i) begin
    if (emit && state_q != ST_IDLE) begin
      pend_q.thread_id_res <= e_tid;
      pend_q.event_res     <= e_ev;
      pend_q.last          <= 1'b0;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (rf_push) rfifo_q[rcnt_q[QIdxW-1:0]] <= req_i.thread_id;
    if (wf_remove) begin
      for (int i = 0; i < QueueDepth - 1; i++) begin
        if (QIdxW'(i) >= wf_rm_idx) begin
          wslot_q[i] <= wslot_q[i+1];
          wdl_q[i]   <= wdl_q[i+1];
          whas_q[i]  <= whas_q[i+1];
        end
      end
    end else if (wf_push) begin
      wslot_q[wcnt_q[QIdxW-1:0]] <= req_i.thread_id;
      wdl_q[wcnt_q[QIdxW-1:0]]   <= now_q + req_i.timeout_ms;
      whas_q[wcnt_q[QIdxW-1:0]]  <= (req_i.timeout_ms != '0);
    end
  end
endmodule

@@ hdl/rwla_out_fifo.sv @@
// result queue presented to the consumer
module rwla_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  rwla_pkg::res_t  res_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rwla_pkg::res_t  res_o
);
  import rwla_pkg::*;

  logic [1:0] cnt_q;
  logic       wptr_q, rptr_q;
  res_t       mem_q [2];
  logic       wr, rd;

  assign ready_o = (cnt_q != 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = mem_q[rptr_q];
  assign wr      = wr_i && ready_o;
  assign rd      = pop_i && !empty_o;

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (wr && !rd) cnt_q <= cnt_q + 2'd1;
      else if (!wr && rd) cnt_q <= cnt_q - 2'd1;
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wptr_q] <= res_i;
  end
endmodule

@@ hdl/reader_writer_lock_arbiter.sv @@
// readers-writer lock arbiter top level
//   channel  | direction | handshake        | payload
//   request  | in        | push / full      | req_i  (mode, thread_id, timeout_ms)
//   result   | out       | empty / pop      | res_o  (thread_id_res, event_res, last)
// a single-result request waits in the front queue until the idle engine takes it while
// the result queue has room; its result is written into the result queue to be popped.
// tick: take, scan the waiting writers and end the scan, decide, release each queued
// reader if the lock is free, close.
// exit-write with queued readers: take, release each reader, close.
// reset clears counts and valid state; queue contents need no clearing.
// a full result queue freezes the engine; two requests still buffer in front.
module reader_writer_lock_arbiter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  rwla_pkg::req_t  req_i,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output rwla_pkg::res_t  res_o
);
  import rwla_pkg::*;

  logic avail, take, rvalid, rready;
  req_t qreq;
  res_t eres;

  rwla_req_fifo u_front (
    .clk_i, .rst_ni, .push_i(push), .req_i, .full_o(full),
    .take_i(take), .avail_o(avail), .req_o(qreq)
  );

  rwla_engine u_engine (
    .clk_i, .rst_ni, .avail_i(avail), .req_i(qreq), .take_o(take),
    .res_valid_o(rvalid), .res_o(eres), .res_ready_i(rready)
  );

  rwla_out_fifo u_back (
    .clk_i, .rst_ni, .wr_i(rvalid), .res_i(eres), .ready_o(rready),
    .pop_i(pop), .empty_o(empty), .res_o
  );
endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for the readers-writer lock arbiter
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rwla_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxShown = 10;

  // directed stimulus row, with an optional typed single result
  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  tid;
    logic [15:0] tmo;
    logic        typed;
    logic [5:0]  exp_tid;
    logic [2:0]  exp_ev;
  } dir_row_t;

  typedef struct {
    logic [5:0]  tid;
    logic [15:0] deadline;
    logic        has_dl;
  } waiter_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  req_t req_i = '0;
  logic full, empty;
  res_t res_o;

  // lock state mirror
  logic [6:0]  readers_held;
  logic        writer_held;
  logic [5:0]  reader_wait_q[$];
  waiter_t     writer_wait_q[$];
  logic [15:0] tick_count;

  res_t        grant_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        recv_hold = 1'b0;
  int unsigned cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;

  dir_row_t dir_tab[] = '{
    '{MODE_EXIT_READ,   6'd0,  16'd0,     1'b1, 6'd0,  EV_MISUSE},
    '{MODE_EXIT_WRITE,  6'd0,  16'd0,     1'b1, 6'd0,  EV_MISUSE},
    '{3'd7,             6'd63, 16'hffff,  1'b1, 6'd0,  EV_MISUSE},
    '{MODE_TICK,        6'd0,  16'd0,     1'b1, 6'd0,  EV_ACK},
    '{MODE_ENTER_READ,  6'd63, 16'hffff,  1'b1, 6'd63, EV_GRANT_NOW},
    '{MODE_ENTER_WRITE, 6'd1,  16'd2,     1'b1, 6'd1,  EV_QUEUED},
    '{MODE_ENTER_WRITE, 6'd2,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_ENTER_READ,  6'd3,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_TICK,        6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_TICK,        6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_EXIT_READ,   6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_ENTER_READ,  6'd4,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_EXIT_WRITE,  6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_EXIT_READ,   6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_EXIT_READ,   6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_ENTER_WRITE, 6'd5,  16'hffff,  1'b0, 6'd0,  EV_ACK},
    '{MODE_ENTER_WRITE, 6'd6,  16'd1,     1'b0, 6'd0,  EV_ACK},
    '{MODE_ENTER_READ,  6'd7,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_TICK,        6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_EXIT_WRITE,  6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{MODE_EXIT_READ,   6'd0,  16'd0,     1'b0, 6'd0,  EV_ACK},
    '{3'd5,             6'd42, 16'h5555,  1'b0, 6'd0,  EV_ACK},
    '{3'd6,             6'd21, 16'haaaa,  1'b0, 6'd0,  EV_ACK}
  };

  reader_writer_lock_arbiter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .req_i  (req_i),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d grants outstanding", cycles, grant_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    pop = !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (grant_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("unexpected result tid=%0d ev=%0d last=%0b",
                   res_o.thread_id_res, res_o.event_res, res_o.last);
      end else begin
        want = grant_q.pop_front();
        if (res_o.thread_id_res !== want.thread_id_res || res_o.event_res !== want.event_res ||
            res_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("mismatch: exp tid=%0d ev=%0d last=%0b, got tid=%0d ev=%0d last=%0b",
                     want.thread_id_res, want.event_res, want.last,
                     res_o.thread_id_res, res_o.event_res, res_o.last);
        end
      end
    end
  end

  // append one result unless the per-request cap is reached
  function automatic void add_result(ref res_t batch[$], input logic [5:0] tid,
                                     input event_e ev);
    res_t r;
    if (batch.size() < MaxResults) begin
      r.thread_id_res = tid;
      r.event_res = ev;
      r.last = 1'b0;
      batch.push_back(r);
    end
  endfunction

  function automatic void release_readers(ref res_t batch[$]);
    foreach (reader_wait_q[i]) begin
      if (readers_held < ReadersMax) readers_held++;
      add_result(batch, reader_wait_q[i], EV_GRANT_WAIT);
    end
    reader_wait_q.delete();
  endfunction

  function automatic void grant_head_writer(ref res_t batch[$]);
    waiter_t w;
    w = writer_wait_q.pop_front();
    writer_held = 1'b1;
    add_result(batch, w.tid, EV_GRANT_WAIT);
  endfunction

  // lock arbitration predictor: updates the mirror and returns the results
  function automatic void predict_lock(input req_t r, ref res_t batch[$]);
    waiter_t w;
    int unsigned k;
    batch.delete();
    case (r.mode)
      MODE_ENTER_READ: begin
        if (!writer_held && writer_wait_q.size() == 0) begin
          if (readers_held >= ReadersMax) add_result(batch, r.thread_id, EV_FULL);
          else begin
            readers_held++;
            add_result(batch, r.thread_id, EV_GRANT_NOW);
          end
        end else if (reader_wait_q.size() >= QueueDepth) begin
          add_result(batch, r.thread_id, EV_FULL);
        end else begin
          reader_wait_q.push_back(r.thread_id);
          add_result(batch, r.thread_id, EV_QUEUED);
        end
      end
      MODE_ENTER_WRITE: begin
        if (readers_held == 0 && !writer_held) begin
          writer_held = 1'b1;
          add_result(batch, r.thread_id, EV_GRANT_NOW);
        end else if (writer_wait_q.size() >= QueueDepth) begin
          add_result(batch, r.thread_id, EV_FULL);
        end else begin
          w.tid = r.thread_id;
          w.deadline = tick_count + r.timeout_ms;
          w.has_dl = (r.timeout_ms != 0);
          writer_wait_q.push_back(w);
          add_result(batch, r.thread_id, EV_QUEUED);
        end
      end
      MODE_EXIT_READ: begin
        if (readers_held == 0) add_result(batch, 6'd0, EV_MISUSE);
        else begin
          readers_held--;
          if (readers_held == 0 && writer_wait_q.size() > 0) grant_head_writer(batch);
          else add_result(batch, 6'd0, EV_ACK);
        end
      end
      MODE_EXIT_WRITE: begin
        if (!writer_held) add_result(batch, 6'd0, EV_MISUSE);
        else begin
          writer_held = 1'b0;
          if (reader_wait_q.size() > 0) release_readers(batch);
          else if (writer_wait_q.size() > 0) grant_head_writer(batch);
          else add_result(batch, 6'd0, EV_ACK);
        end
      end
      MODE_TICK: begin
        tick_count++;
        k = 0;
        while (k < writer_wait_q.size()) begin
          if (writer_wait_q[k].has_dl && writer_wait_q[k].deadline == tick_count) begin
            add_result(batch, writer_wait_q[k].tid, EV_TIMEOUT);
            writer_wait_q.delete(k);
          end else k++;
        end
        if (!writer_held && writer_wait_q.size() == 0 && reader_wait_q.size() > 0)
          release_readers(batch);
        if (batch.size() == 0) add_result(batch, 6'd0, EV_ACK);
      end
      default: add_result(batch, 6'd0, EV_MISUSE);
    endcase
    batch[batch.size() - 1].last = 1'b1;
  endfunction

  // offer one request, wait for acceptance, then record what it should cause
  task automatic send_request(input req_t r, input logic typed, input res_t typed_res);
    res_t batch[$];
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (full);
    requests_sent++;
    predict_lock(r, batch);
    if (typed) grant_q.push_back(typed_res);
    else foreach (batch[i]) grant_q.push_back(batch[i]);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  // random request, mostly well-formed lock traffic with small timeouts
  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.thread_id = 6'($urandom_range(63));
    if (pick < 30) r.mode = MODE_ENTER_READ;
    else if (pick < 58) r.mode = MODE_ENTER_WRITE;
    else if (pick < 72) r.mode = MODE_EXIT_READ;
    else if (pick < 84) r.mode = MODE_EXIT_WRITE;
    else if (pick < 97) r.mode = MODE_TICK;
    else r.mode = 3'($urandom_range(7, 5));
    case ($urandom_range(9))
      0, 1: r.timeout_ms = 16'd0;
      2:    r.timeout_ms = 16'($urandom);
      default: r.timeout_ms = 16'($urandom_range(6, 1));
    endcase
    return r;
  endfunction

  initial begin
    req_t r;
    res_t tr;
    readers_held = '0;
    writer_held = 1'b0;
    tick_count = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      r.mode = dir_tab[i].mode;
      r.thread_id = dir_tab[i].tid;
      r.timeout_ms = dir_tab[i].tmo;
      tr.thread_id_res = dir_tab[i].exp_tid;
      tr.event_res = dir_tab[i].exp_ev;
      tr.last = 1'b1;
      send_request(r, dir_tab[i].typed, tr);
    end

    // random phases, the first one under a long result hold-off
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 0) begin
        fork
          begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 45; i++) send_request(random_request(), 1'b0, tr);
    end

    // drain, then allow trailing results to show up
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("%0d requests issued (directed corner cases, random traffic under stalls)",
             requests_sent);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rwla_pkg.sv
hdl/rwla_req_fifo.sv
hdl/rwla_engine.sv
hdl/rwla_out_fifo.sv
hdl/reader_writer_lock_arbiter.sv
tb/sv/tb.sv
